@@ src/eida_pkg.sv @@
// Shared types and constants for the entity identifier allocator.
package eida_pkg;

   // Field widths of one request and one response.
   localparam int CMD_W       = 2;
   localparam int ENT_W       = 12;
   localparam int COMP_W      = 5;
   localparam int BITV_W      = 1;
   localparam int STATUS_W    = 2;
   localparam int GRANT_W     = 12;
   localparam int SIG_OUT_W   = 32;
   localparam int LIVING_W    = 13;

   // Request tdata layout, lowest bit first.
   localparam int REQ_CMD_LSB  = 0;
   localparam int REQ_ENT_LSB  = REQ_CMD_LSB + CMD_W;
   localparam int REQ_COMP_LSB = REQ_ENT_LSB + ENT_W;
   localparam int REQ_BITV_LSB = REQ_COMP_LSB + COMP_W;
   localparam int REQ_USED_W   = REQ_BITV_LSB + BITV_W;
   localparam int REQ_TDATA_W  = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest bit first.
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_GRANT_LSB  = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_SIG_LSB    = RSP_GRANT_LSB + GRANT_W;
   localparam int RSP_LIVING_LSB = RSP_SIG_LSB + SIG_OUT_W;
   localparam int RSP_USED_W     = RSP_LIVING_LSB + LIVING_W;
   localparam int RSP_TDATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_SET_BIT = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_FREE = 2'd1,
      STAT_NONE    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

@@ src/eida_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module eida_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/entity_id_allocator_with_signatures_core.sv @@
// Entity identifier allocator: free-ID FIFO and per-ID signature table in RAM.
//
// Requests arrive on the req_ stream: a command (create, destroy, set signature
// bit, read signature) with an entity index, a bit position and a bit value.
// Every request yields exactly one response on the rsp_ stream carrying a
// status, the granted identifier, the read signature and the living count after
// the command.
//
// Each request is handled in an accept step and an execute step: the accept edge
// issues the reads of the free FIFO (at its head) and of the signature table,
// and the execute state modifies and writes both memories back and loads the
// response register. With one read port per memory, a new request is not taken
// until the execute state of the last one has finished.
//
// After reset the block runs a clearing pass over every slot that loads the
// FIFO with 0..ENTITY_SLOTS-1 and zeroes every signature; req_tready stays low
// for its duration. A new request is taken while an earlier response still
// waits in the output register; if the receiver stalls, the second request
// waits in its execute state until the output register is free.
module entity_id_allocator_with_signatures_core #(
   parameter int ENTITY_SLOTS   = 4096,
   parameter int COMPONENT_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: cmd[1:0], entity_index[13:2], component_index[18:14], bit_value[19]
   input  logic [eida_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: status[1:0], granted_id[13:2], signature_out[45:14], living_total[58:46]
   output logic [eida_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);

   localparam int AW = $clog2(ENTITY_SLOTS);
   localparam int CW = $clog2(ENTITY_SLOTS + 1);

   eida_pkg::state_type state_ff, state_in;

   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] living_ff, living_in;

   // Captured request.
   eida_pkg::cmd_type               cmd_ff, cmd_in;
   logic                            ent_ok_ff, ent_ok_in;
   logic [AW-1:0]                   ent_addr_ff, ent_addr_in;
   logic [eida_pkg::COMP_W-1:0]     comp_ff, comp_in;
   logic                            bitv_ff, bitv_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [eida_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic exec_go;
   logic clearing;

   // Request fields.
   eida_pkg::cmd_type             req_cmd;
   logic [eida_pkg::ENT_W-1:0]    req_ent;
   logic [eida_pkg::COMP_W-1:0]   req_comp;
   logic                          req_bitv;
   logic [31:0]                   req_ent_wide;

   // Memory ports.
   logic                      q_we;
   logic [AW-1:0]             q_waddr;
   logic [AW-1:0]             q_wdata;
   logic [AW-1:0]             q_rdata;
   logic                      s_we;
   logic [AW-1:0]             s_waddr;
   logic [COMPONENT_BITS-1:0] s_wdata;
   logic [COMPONENT_BITS-1:0] s_rdata;

   // Execute datapath.
   logic                             comp_ok;
   logic [COMPONENT_BITS-1:0]        bit_mask;
   logic [31:0]                      grant_wide;
   logic [63:0]                      sig_wide;
   logic [31:0]                      living_wide;
   eida_pkg::status_type             status;
   logic [eida_pkg::GRANT_W-1:0]     granted;
   logic [eida_pkg::SIG_OUT_W-1:0]   sig_out;

   assign req_cmd  = eida_pkg::cmd_type'(req_tdata[eida_pkg::REQ_CMD_LSB +: eida_pkg::CMD_W]);
   assign req_ent  = req_tdata[eida_pkg::REQ_ENT_LSB +: eida_pkg::ENT_W];
   assign req_comp = req_tdata[eida_pkg::REQ_COMP_LSB +: eida_pkg::COMP_W];
   assign req_bitv = req_tdata[eida_pkg::REQ_BITV_LSB];
   assign req_ent_wide = 32'(req_ent);

   assign req_accept = req_tvalid && req_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eida_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(ENTITY_SLOTS - 1)) begin
               state_in = eida_pkg::ST_IDLE;
            end
         end
         eida_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = eida_pkg::ST_EXEC;
            end
         end
         eida_pkg::ST_EXEC: begin
            if (exec_go) begin
               state_in = eida_pkg::ST_IDLE;
            end
         end
         default: state_in = eida_pkg::ST_CLEAR;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      clearing   = 1'b0;
      exec_go    = 1'b0;
      case (state_ff)
         eida_pkg::ST_CLEAR: clearing = 1'b1;
         eida_pkg::ST_IDLE:  req_tready = 1'b1;
         eida_pkg::ST_EXEC:  exec_go = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Request capture.
   always_comb begin
      cmd_in      = cmd_ff;
      ent_ok_in   = ent_ok_ff;
      ent_addr_in = ent_addr_ff;
      comp_in     = comp_ff;
      bitv_in     = bitv_ff;
      if (req_accept) begin
         cmd_in      = req_cmd;
         ent_ok_in   = req_ent_wide < 32'(ENTITY_SLOTS);
         ent_addr_in = req_ent_wide[AW-1:0];
         comp_in     = req_comp;
         bitv_in     = req_bitv;
      end
   end

   assign comp_ok    = 32'(comp_ff) < 32'(COMPONENT_BITS);
   assign bit_mask   = COMPONENT_BITS'(1) << comp_ff;
   assign grant_wide = 32'(q_rdata);
   assign sig_wide   = 64'(s_rdata);

   // Clearing pass writes, and execute: read data from the accept edge is modified and written back here.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      living_in = living_ff;
      clr_in    = clr_ff;
      q_we      = 1'b0;
      q_waddr   = tail_ff;
      q_wdata   = ent_addr_ff;
      s_we      = 1'b0;
      s_waddr   = ent_addr_ff;
      s_wdata   = '0;
      status    = eida_pkg::STAT_OK;
      granted   = '0;
      sig_out   = '0;

      if (clearing) begin
         q_we    = 1'b1;
         q_waddr = clr_ff;
         q_wdata = clr_ff;
         s_we    = 1'b1;
         s_waddr = clr_ff;
         clr_in  = clr_ff + AW'(1);
      end else if (exec_go) begin
         case (cmd_ff)
            eida_pkg::CMD_CREATE: begin
               if (living_ff == CW'(ENTITY_SLOTS)) begin
                  status = eida_pkg::STAT_NO_FREE;
               end else begin
                  granted   = grant_wide[eida_pkg::GRANT_W-1:0];
                  head_in   = (head_ff == AW'(ENTITY_SLOTS - 1)) ? '0 : head_ff + AW'(1);
                  living_in = living_ff + CW'(1);
               end
            end
            eida_pkg::CMD_DESTROY: begin
               if (living_ff == '0) begin
                  status = eida_pkg::STAT_NONE;
               end else if (ent_ok_ff) begin
                  s_we      = 1'b1;
                  q_we      = 1'b1;
                  tail_in   = (tail_ff == AW'(ENTITY_SLOTS - 1)) ? '0 : tail_ff + AW'(1);
                  living_in = living_ff - CW'(1);
               end
            end
            eida_pkg::CMD_SET_BIT: begin
               if (ent_ok_ff && comp_ok) begin
                  s_we    = 1'b1;
                  s_wdata = bitv_ff ? (s_rdata | bit_mask) : (s_rdata & ~bit_mask);
               end
            end
            eida_pkg::CMD_READ: begin
               if (ent_ok_ff) begin
                  sig_out = sig_wide[eida_pkg::SIG_OUT_W-1:0];
               end
            end
            default: begin
               status = eida_pkg::STAT_OK;
            end
         endcase
      end
   end

   assign living_wide = 32'(living_in);

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eida_pkg::RSP_TDATA_W'({
            living_wide[eida_pkg::LIVING_W-1:0], sig_out, granted, status});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eida_pkg::ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         living_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         living_ff    <= living_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ent_ok_ff   <= ent_ok_in;
      ent_addr_ff <= ent_addr_in;
      comp_ff     <= comp_in;
      bitv_ff     <= bitv_in;
      rsp_data_ff <= rsp_data_in;
   end

   eida_ram #(
      .WIDTH (AW),
      .DEPTH (ENTITY_SLOTS)
   ) u_free_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (req_accept),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   eida_ram #(
      .WIDTH (COMPONENT_BITS),
      .DEPTH (ENTITY_SLOTS)
   ) u_sig_table (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_ent_wide[AW-1:0]),
      .rd_data (s_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/eida_checker.sv @@
// Port-level checks for the entity identifier allocator, bound to its top level.
module eida_checker (
   input logic                             clock,
   input logic                             reset,
   input logic [eida_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [eida_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);

   logic [eida_pkg::STATUS_W-1:0]  rsp_status;
   logic [eida_pkg::GRANT_W-1:0]   rsp_granted;
   logic [eida_pkg::SIG_OUT_W-1:0] rsp_sig;

   assign rsp_status  = rsp_tdata[eida_pkg::RSP_STATUS_LSB +: eida_pkg::STATUS_W];
   assign rsp_granted = rsp_tdata[eida_pkg::RSP_GRANT_LSB +: eida_pkg::GRANT_W];
   assign rsp_sig     = rsp_tdata[eida_pkg::RSP_SIG_LSB +: eida_pkg::SIG_OUT_W];

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Only one request is in execution at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during execution");

   // The clearing pass follows reset: no request taken, no response shown.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");

   // A refused command carries neither an identifier nor a signature.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != eida_pkg::STAT_OK |-> rsp_granted == '0 && rsp_sig == '0)
      else $error("refused command returned data");

endmodule

bind entity_id_allocator_with_signatures_core eida_checker u_eida_checker (.*);
